// ----- src/sfs_pkg.sv -----
// shared types, constants and segment tables for the seven-segment frame sequencer
`default_nettype none
package sfs_pkg;

  localparam int unsigned SHOW_BYTES  = 8;
  localparam int unsigned DIGIT_CODES = 18;

  localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
  localparam logic [7:0] CMD_ADDRESS    = 8'hC0;

  // low and high segment bytes for each digit code: hex 0-f, blank, dash
  localparam logic [7:0] SEG_LOW [DIGIT_CODES] = '{
    8'hE8, 8'h08, 8'hD8, 8'h98, 8'h38, 8'hB8, 8'hF8, 8'h08, 8'hF8,
    8'hB8, 8'h70, 8'hF0, 8'hE0, 8'hD0, 8'hF0, 8'h70, 8'h00, 8'h10
  };

  localparam logic [7:0] SEG_HIGH [DIGIT_CODES] = '{
    8'h0B, 8'h03, 8'h0A, 8'h0B, 8'h03, 8'h09, 8'h09, 8'h0B, 8'h0B,
    8'h0B, 8'h0B, 8'h01, 8'h08, 8'h03, 8'h08, 8'h08, 8'h00, 8'h00
  };

  typedef struct packed {
    logic       req_type;
    logic [4:0] digit_pos3;
    logic [4:0] digit_pos2;
    logic [4:0] digit_pos1;
    logic [4:0] digit_pos0;
  } sfs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       last;
  } sfs_out_t;

  // classified request as it waits between front and back
  typedef struct packed {
    logic                       clear;
    logic [SHOW_BYTES-1:0][7:0] bytes;
  } sfs_cmd_t;

  typedef enum logic {
    SFS_IDLE,
    SFS_RUN
  } sfs_state_t;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_ADDR,
    PH_DATA
  } sfs_phase_t;

  localparam logic REQ_SHOW  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  function automatic logic [7:0] seg_lo(input logic [4:0] code);
    logic [7:0] val;
    val = 8'h00;
    if (code < 5'(DIGIT_CODES)) begin
      val = SEG_LOW[code];
    end
    return val;
  endfunction

  function automatic logic [7:0] seg_hi(input logic [4:0] code);
    logic [7:0] val;
    val = 8'h00;
    if (code < 5'(DIGIT_CODES)) begin
      val = SEG_HIGH[code];
    end
    return val;
  endfunction

endpackage
`default_nettype wire

// ----- src/sfs_front.sv -----
// front end: classifies a request and maps digit codes to segment bytes
`default_nettype none
module sfs_front
  import sfs_pkg::*;
(
  input  wire sfs_in_t  req,
  output sfs_cmd_t      cmd
);

  always_comb begin
    cmd.clear    = (req.req_type == REQ_CLEAR);
    // rightmost digit lands at the lowest addresses
    cmd.bytes[0] = seg_lo(req.digit_pos0);
    cmd.bytes[1] = seg_hi(req.digit_pos0);
    cmd.bytes[2] = seg_lo(req.digit_pos1);
    cmd.bytes[3] = seg_hi(req.digit_pos1);
    cmd.bytes[4] = seg_lo(req.digit_pos2);
    cmd.bytes[5] = seg_hi(req.digit_pos2);
    cmd.bytes[6] = seg_lo(req.digit_pos3);
    cmd.bytes[7] = seg_hi(req.digit_pos3);
  end

endmodule
`default_nettype wire

// ----- src/sfs_cmd_fifo.sv -----
// two-entry command queue between the front end and the frame sequencer
`default_nettype none
module sfs_cmd_fifo
  import sfs_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  input  wire           wr_en,
  input  wire sfs_cmd_t wr_cmd,
  output logic          full,
  input  wire           rd_en,
  output sfs_cmd_t      rd_cmd,
  output logic          empty
);

  sfs_cmd_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign full   = (cnt_r == 2'd2);
  assign empty  = (cnt_r == 2'd0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- src/sfs_back.sv -----
// back end: updates the display shadow and walks it out as command frames
`default_nettype none
module sfs_back
  import sfs_pkg::*;
#(
  parameter int unsigned DISPLAY_BYTES = 14
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           cmd_empty,
  input  wire sfs_cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  output sfs_out_t      out_item,
  input  wire           out_pop
);

  localparam int unsigned AW = $clog2(DISPLAY_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DISPLAY_BYTES - 1);

  logic [7:0]  shadow_r [DISPLAY_BYTES];
  logic [7:0]  show_val [DISPLAY_BYTES];

  sfs_state_t  state_r, state_nxt;
  sfs_phase_t  phase_r, phase_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic        out_valid_r, out_valid_nxt;
  sfs_out_t    out_r, out_nxt;
  logic        slot_free;

  // a show request leaves the upper bytes as they are
  for (genvar j = 0; j < DISPLAY_BYTES; j++) begin : g_show
    if (j < SHOW_BYTES) begin : g_dig
      assign show_val[j] = cmd.bytes[j];
    end else begin : g_keep
      assign show_val[j] = shadow_r[j];
    end
  end

  assign slot_free = !out_valid_r || out_pop;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    addr_nxt      = addr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_pop ? 1'b0 : out_valid_r;
    cmd_pop       = 1'b0;
    unique case (state_r)
      SFS_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          state_nxt = SFS_RUN;
          phase_nxt = PH_CMD;
          addr_nxt  = '0;
        end
      end
      SFS_RUN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          unique case (phase_r)
            PH_CMD: begin
              out_nxt   = '{out_byte: CMD_FIXED_ADDR, frame_end: 1'b1, last: 1'b0};
              phase_nxt = PH_ADDR;
            end
            PH_ADDR: begin
              out_nxt   = '{out_byte: CMD_ADDRESS | 8'(addr_r), frame_end: 1'b0,
                            last: 1'b0};
              phase_nxt = PH_DATA;
            end
            PH_DATA: begin
              out_nxt   = '{out_byte: shadow_r[addr_r], frame_end: 1'b1,
                            last: (addr_r == LAST_ADDR)};
              phase_nxt = PH_CMD;
              if (addr_r == LAST_ADDR) begin
                state_nxt = SFS_IDLE;
              end else begin
                addr_nxt = addr_r + 1'b1;
              end
            end
            default: begin
              phase_nxt = PH_CMD;
            end
          endcase
        end
      end
      default: begin
        state_nxt = SFS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SFS_IDLE;
      phase_r     <= PH_CMD;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DISPLAY_BYTES; i++) begin
      if (!rst_n) begin
        shadow_r[i] <= 8'h00;
      end else if (cmd_pop) begin
        shadow_r[i] <= cmd.clear ? 8'h00 : show_val[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/seven_segment_frame_sequencer.sv -----
// top level of the seven-segment frame sequencer
//
//   channel  handshake     payload    direction
//   request  push / full   in_data    in
//   result   empty / pop   out_data   out
//
// each request yields 3 * DISPLAY_BYTES result bytes, one per cycle while the
// result side keeps popping; taking the next queued command and updating the
// shadow happens in the idle state before each run.
// the two-entry command queue lets requests arrive while a run is going out.
// reset zeroes the display shadow and empties the queue and the result register.
// a stalled result holds the byte sequencer; full rises once the queue has two commands.
`default_nettype none
module seven_segment_frame_sequencer
  import sfs_pkg::*;
#(
  parameter int unsigned DISPLAY_BYTES = 14
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  output logic         full,
  input  wire sfs_in_t in_data,
  output logic         empty,
  input  wire          pop,
  output sfs_out_t     out_data
);

  sfs_cmd_t front_cmd;
  sfs_cmd_t q_cmd;
  logic     q_empty;
  logic     q_pop;
  logic     out_valid;

  sfs_front u_front (
    .req (in_data),
    .cmd (front_cmd)
  );

  sfs_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_cmd (front_cmd),
    .full   (full),
    .rd_en  (q_pop),
    .rd_cmd (q_cmd),
    .empty  (q_empty)
  );

  sfs_back #(
    .DISPLAY_BYTES (DISPLAY_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_item  (out_data),
    .out_pop   (pop)
  );

  assign empty = !out_valid;

  // the final byte of a run always closes a frame
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.last |-> out_data.frame_end)
    else $error("last byte does not end a frame");

  // bytes inside an open frame are address commands
  a_open_is_address: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_data.frame_end |-> out_data.out_byte[7:6] == 2'b11)
    else $error("open-frame byte is not an address command");

  // an address command transfer is followed at once by its data byte
  a_data_follows_addr: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && pop && !out_data.frame_end |=> !empty && out_data.frame_end)
    else $error("data byte missing after address command");

endmodule
`default_nettype wire

// ----- bench/tb_seven_segment_frame_sequencer.sv -----
// testbench for the seven-segment frame sequencer: predicted byte runs checked per transfer
module tb_seven_segment_frame_sequencer;
  import sfs_pkg::*;

  localparam int unsigned NUM_ADDR     = 14;
  localparam logic [4:0]  BLANK_CODE   = 5'd16;
  localparam logic [4:0]  DASH_CODE    = 5'd17;
  localparam int unsigned KNOWN_CODES  = 18;
  localparam int unsigned DRAIN_CYCLES = 3 * NUM_ADDR + 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  // segment patterns per digit code: hex 0-f, blank, dash
  localparam logic [7:0] LOW_SEGS [KNOWN_CODES] = '{
    8'hE8, 8'h08, 8'hD8, 8'h98, 8'h38, 8'hB8, 8'hF8, 8'h08, 8'hF8,
    8'hB8, 8'h70, 8'hF0, 8'hE0, 8'hD0, 8'hF0, 8'h70, 8'h00, 8'h10
  };
  localparam logic [7:0] HIGH_SEGS [KNOWN_CODES] = '{
    8'h0B, 8'h03, 8'h0A, 8'h0B, 8'h03, 8'h09, 8'h09, 8'h0B, 8'h0B,
    8'h0B, 8'h0B, 8'h01, 8'h08, 8'h03, 8'h08, 8'h08, 8'h00, 8'h00
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  sfs_in_t  in_data = '0;
  logic     full;
  logic     empty;
  sfs_out_t out_data;

  logic [7:0] shadow_copy [NUM_ADDR];
  sfs_out_t   bytes_due [$];
  int         errors = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         pop_stall_pct = 0;

  seven_segment_frame_sequencer #(
    .DISPLAY_BYTES(NUM_ADDR)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic sfs_out_t frame_byte(logic [7:0] b, logic fend, logic lst);
    sfs_out_t r;
    r.out_byte  = b;
    r.frame_end = fend;
    r.last      = lst;
    return r;
  endfunction

  function automatic void write_digit(int unsigned addr, logic [4:0] code);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h00;
    hi = 8'h00;
    if (code < KNOWN_CODES) begin
      lo = LOW_SEGS[code];
      hi = HIGH_SEGS[code];
    end
    shadow_copy[addr]     = lo;
    shadow_copy[addr + 1] = hi;
  endfunction

  // update the shadow copy and queue the full refresh run it triggers
  function automatic void predict_refresh(sfs_in_t req);
    if (req.req_type == REQ_CLEAR) begin
      for (int i = 0; i < NUM_ADDR; i++) shadow_copy[i] = 8'h00;
    end else begin
      write_digit(0, req.digit_pos0);
      write_digit(2, req.digit_pos1);
      write_digit(4, req.digit_pos2);
      write_digit(6, req.digit_pos3);
    end
    for (int i = 0; i < NUM_ADDR; i++) begin
      bytes_due.push_back(frame_byte(CMD_FIXED_ADDR, 1'b1, 1'b0));
      bytes_due.push_back(frame_byte(CMD_ADDRESS | 8'(i), 1'b0, 1'b0));
      bytes_due.push_back(frame_byte(shadow_copy[i], 1'b1, i == NUM_ADDR - 1));
    end
  endfunction

  // result side: check every transfer, then decide whether to stall next cycle
  always @(posedge clk) begin
    sfs_out_t want;
    if (rst_n && pop && !empty) begin
      if (bytes_due.size() == 0) begin
        $error("unexpected transfer: out_byte %h", out_data.out_byte);
        errors++;
      end else begin
        want = bytes_due.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, out_data.frame_end);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_data.last);
          errors++;
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // push stays high after a transfer so back-to-back requests need no second assignment
  task automatic send_req(input sfs_in_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (full);
    predict_refresh(req);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic sfs_in_t show_req(logic [4:0] c3, logic [4:0] c2, logic [4:0] c1,
                                       logic [4:0] c0);
    sfs_in_t r;
    r.req_type   = REQ_SHOW;
    r.digit_pos3 = c3;
    r.digit_pos2 = c2;
    r.digit_pos1 = c1;
    r.digit_pos0 = c0;
    return r;
  endfunction

  function automatic sfs_in_t clear_req(logic [4:0] fill);
    sfs_in_t r;
    r            = show_req(fill, fill, fill, fill);
    r.req_type   = REQ_CLEAR;
    return r;
  endfunction

  function automatic logic [4:0] rand_code();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, KNOWN_CODES - 1));
  endfunction

  task automatic test_hex_digits();
    send_req(show_req(3, 2, 1, 0));
    send_req(show_req(7, 6, 5, 4));
    send_req(show_req(11, 10, 9, 8));
    send_req(show_req(15, 14, 13, 12));
    send_req(show_req(BLANK_CODE, DASH_CODE, 0, 15));
    send_req(show_req(DASH_CODE, BLANK_CODE, DASH_CODE, BLANK_CODE));
    drain();
  endtask

  // codes past dash must show as blank, also over a lit digit
  task automatic test_unknown_codes();
    send_req(show_req(8, 8, 8, 8));
    send_req(show_req(18, 31, 19, 24));
    send_req(show_req(8, 8, 8, 8));
    send_req(show_req(20, 25, 30, 31));
    send_req(show_req(0, 31, DASH_CODE, 18));
    send_req(show_req(31, 31, 31, 31));
    drain();
  endtask

  task automatic test_clear();
    send_req(show_req(8, 8, 8, 8));
    send_req(clear_req(5'd0));
    send_req(show_req(0, 0, 0, 0));
    send_req(clear_req(5'd31));
    send_req(clear_req(5'd8));
    send_req(show_req(15, 10, 5, 1));
    send_req(clear_req(5'd21));
    drain();
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct, input int n_reqs);
    sfs_in_t req;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    for (int i = 0; i < n_reqs; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        req = clear_req(5'($urandom_range(0, 31)));
      end else begin
        req = show_req(rand_code(), rand_code(), rand_code(), rand_code());
      end
      send_req(req);
    end
    drain();
    send_idle_pct = 0;
    pop_stall_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < NUM_ADDR; i++) shadow_copy[i] = 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_hex_digits();
    test_unknown_codes();
    test_clear();
    test_random(0, 0, 80);
    test_random(63, 0, 70);
    test_random(0, 63, 70);
    test_random(18, 18, 70);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- seven_segment_frame_sequencer.f -----
src/sfs_pkg.sv
src/sfs_front.sv
src/sfs_cmd_fifo.sv
src/sfs_back.sv
src/seven_segment_frame_sequencer.sv
bench/tb_seven_segment_frame_sequencer.sv
